// ===== hdl/lss_pkg.sv =====
// Shared types and codes for the LIFO stack with search.
// No dependencies.
package lss_pkg;

  typedef enum logic [2:0] {
    MODE_PUSH  = 3'd0,
    MODE_POP   = 3'd1,
    MODE_PEEK  = 3'd2,
    MODE_CLEAR = 3'd3,
    MODE_FIND  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_FIND = 3'b100
  } state_e;

  localparam int unsigned WordW  = 32;
  localparam int unsigned IndexW = 6;
  localparam int unsigned CountW = 7;

endpackage

// ===== hdl/lifo_stack_with_search_unit.sv =====
// LIFO stack of signed words with bottom-up search, held in one synchronous RAM.
// Depends on lss_pkg.
//
// channel  | ports                                         | handshake
// request  | mode_i, value_i                               | start & !busy
// result   | data_out_o, status_o, found_o, found_index_o, | valid_o, one cycle
//          | count_o, is_empty_o                           |
//
// Push, clear, refused requests and unused modes complete straight from idle.
// Pop and peek: one RAM read, through S_READ. Find scans upward from the bottom in
// S_FIND and ends at the first match or at the top word; an empty stack completes
// straight from idle; one RAM read per word scanned, through the single read port.
// Reset clears the word count; RAM contents need no clearing.
// Results are registered; the receiver cannot stall.
module lifo_stack_with_search_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [2:0]                            mode_i,
  input  logic signed [lss_pkg::WordW-1:0]      value_i,
  output logic                                  valid_o,
  output logic signed [lss_pkg::WordW-1:0]      data_out_o,
  output logic [1:0]                            status_o,
  output logic                                  found_o,
  output logic [lss_pkg::IndexW-1:0]            found_index_o,
  output logic [lss_pkg::CountW-1:0]            count_o,
  output logic                                  is_empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [lss_pkg::WordW-1:0] mem [DEPTH];

  lss_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] scan_q, scan_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic          rd_vld_q, rd_vld_d;
  logic signed [lss_pkg::WordW-1:0] key_q, key_d;
  logic signed [lss_pkg::WordW-1:0] rdata_q;

  logic                             valid_q, valid_d;
  logic signed [lss_pkg::WordW-1:0] data_q, data_d;
  lss_pkg::status_e                 status_q, status_d;
  logic                             found_q, found_d;
  logic [AW-1:0]                    fidx_q, fidx_d;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr;
  logic          accept, is_full, is_zero;

  assign accept  = start && (state_q == lss_pkg::S_IDLE);
  assign is_full = (cnt_q == CW'(DEPTH));
  assign is_zero = (cnt_q == '0);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    scan_d   = scan_q;
    rd_idx_d = rd_idx_q;
    rd_vld_d = 1'b0;
    key_d    = key_q;
    valid_d  = 1'b0;
    data_d   = data_q;
    status_d = status_q;
    found_d  = found_q;
    fidx_d   = fidx_q;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    rd_addr  = scan_q[AW-1:0];

    unique case (state_q)
      lss_pkg::S_IDLE: begin
        if (accept) begin
          data_d   = '0;
          status_d = lss_pkg::ST_OK;
          found_d  = 1'b0;
          fidx_d   = '0;
          unique case (mode_i)
            lss_pkg::MODE_PUSH: begin
              valid_d = 1'b1;
              if (is_full) begin
                status_d = lss_pkg::ST_FULL;
              end else begin
                wr_en = 1'b1;
                cnt_d = cnt_q + CW'(1);
              end
            end
            lss_pkg::MODE_POP, lss_pkg::MODE_PEEK: begin
              if (is_zero) begin
                valid_d  = 1'b1;
                status_d = lss_pkg::ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = AW'(cnt_q - CW'(1));
                state_d = lss_pkg::S_READ;
                if (mode_i == lss_pkg::MODE_POP) begin
                  cnt_d = cnt_q - CW'(1);
                end
              end
            end
            lss_pkg::MODE_CLEAR: begin
              valid_d = 1'b1;
              cnt_d   = '0;
            end
            lss_pkg::MODE_FIND: begin
              if (is_zero) begin
                valid_d = 1'b1;
              end else begin
                key_d   = value_i;
                scan_d  = '0;
                state_d = lss_pkg::S_FIND;
              end
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end
      lss_pkg::S_READ: begin
        valid_d = 1'b1;
        data_d  = rdata_q;
        state_d = lss_pkg::S_IDLE;
      end
      lss_pkg::S_FIND: begin
        if (scan_q < cnt_q) begin
          rd_en    = 1'b1;
          rd_addr  = scan_q[AW-1:0];
          rd_vld_d = 1'b1;
          rd_idx_d = scan_q[AW-1:0];
          scan_d   = scan_q + CW'(1);
        end
        if (rd_vld_q && (rdata_q == key_q)) begin
          valid_d  = 1'b1;
          found_d  = 1'b1;
          fidx_d   = rd_idx_q;
          rd_vld_d = 1'b0;
          state_d  = lss_pkg::S_IDLE;
        end else if (rd_vld_q && ((CW'(rd_idx_q) + CW'(1)) == cnt_q)) begin
          valid_d  = 1'b1;
          rd_vld_d = 1'b0;
          state_d  = lss_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lss_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[AW-1:0]] <= value_i;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lss_pkg::S_IDLE;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q   <= scan_d;
    rd_idx_q <= rd_idx_d;
    key_q    <= key_d;
    data_q   <= data_d;
    status_q <= status_d;
    found_q  <= found_d;
    fidx_q   <= fidx_d;
  end

  assign busy          = (state_q != lss_pkg::S_IDLE);
  assign valid_o       = valid_q;
  assign data_out_o    = data_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign found_index_o = lss_pkg::IndexW'(fidx_q);
  assign count_o       = lss_pkg::CountW'(cnt_q);
  assign is_empty_o    = is_zero;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("word count above depth");

  a_no_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !valid_o)
    else $error("result strobe while busy");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i == lss_pkg::MODE_PUSH) && !is_full) |=>
      (cnt_q == $past(cnt_q) + CW'(1)) && valid_o)
    else $error("push did not grow the stack");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && found_o) |-> (status_o == lss_pkg::ST_OK) && (data_out_o == '0))
    else $error("find hit with bad status or data");

  a_find_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lss_pkg::S_FIND) |-> (scan_q <= cnt_q))
    else $error("search ran past the top of the stack");

endmodule
